>>> rtl/core/mrkt_pkg.sv
// Shared constants for the max-RGB knee tone compressor.
package mrkt_pkg;

   localparam int CSR_INDEX_WIDTH = 1;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_KNEE_LEVEL = 1'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PEAK_LEVEL = 1'd1;

endpackage

>>> rtl/core/max_rgb_knee_tone_compressor.sv
// Max-RGB knee tone compressor: pipelined Reinhard curve on the largest channel.
//
// One pixel is accepted per clock and one result leaves per clock while the
// result side does not stall. The stages are: one for the max and bypass
// decision, one for the headroom product, SAMPLE_WIDTH restoring-division
// stages for the knee curve, one stage for f and the three channel products,
// SAMPLE_WIDTH division stages for the per-channel scaling, and the output register.
// A stall on the result side holds the whole pipeline; nothing is dropped.
// knee_level and peak_level may only be written while the pipeline is empty.
module max_rgb_knee_tone_compressor #(
   parameter int SAMPLE_WIDTH  = 24,
   parameter int FRACTION_BITS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [SAMPLE_WIDTH-1:0]               req_red_in,
   input  logic [SAMPLE_WIDTH-1:0]               req_green_in,
   input  logic [SAMPLE_WIDTH-1:0]               req_blue_in,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [SAMPLE_WIDTH-1:0]               rsp_red_out,
   output logic [SAMPLE_WIDTH-1:0]               rsp_green_out,
   output logic [SAMPLE_WIDTH-1:0]               rsp_blue_out,
   output logic                                  rsp_was_compressed,
   input  logic                                  csr_write_enable,
   input  logic [mrkt_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [SAMPLE_WIDTH-1:0]               csr_write_data
);
   import mrkt_pkg::*;

   localparam int W  = SAMPLE_WIDTH;
   localparam int PW = 2 * SAMPLE_WIDTH;
   localparam logic [W-1:0] FIXED_ONE = W'(1) << FRACTION_BITS;

   logic [W-1:0] knee_ff;
   logic [W-1:0] peak_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         knee_ff <= FIXED_ONE;
         peak_ff <= FIXED_ONE;
      end else if (csr_write_enable) begin
         if (csr_index == CSR_KNEE_LEVEL) begin
            knee_ff <= csr_write_data;
         end
         if (csr_index == CSR_PEAK_LEVEL) begin
            peak_ff <= csr_write_data;
         end
      end
   end

   logic en;
   logic out_valid_ff;
   assign en        = !out_valid_ff || rsp_ready;
   assign req_ready = en;

   // stage A: max and bypass decision
   logic [W-1:0] max_rg, max_in;
   logic         pass_in;
   assign max_rg  = (req_red_in > req_green_in) ? req_red_in : req_green_in;
   assign max_in  = (req_blue_in > max_rg) ? req_blue_in : max_rg;
   assign pass_in = (peak_ff <= FIXED_ONE) || (knee_ff >= peak_ff) || (max_in <= knee_ff);

   logic         a_valid_ff, a_pass_ff;
   logic [W-1:0] a_r_ff, a_g_ff, a_b_ff, a_m_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (en) begin
         a_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_pass_ff <= pass_in;
         a_r_ff    <= req_red_in;
         a_g_ff    <= req_green_in;
         a_b_ff    <= req_blue_in;
         a_m_ff    <= max_in;
      end
   end

   // stage B (index 0 of the first divider): headroom product and divisor
   logic [W-1:0] x_a, hp_a;
   assign x_a  = a_m_ff - knee_ff;
   assign hp_a = peak_ff - knee_ff;

   logic [PW-1:0] prod_in;
   logic [W:0]    den_in;
   assign prod_in = {{W{1'b0}}, hp_a} * {{W{1'b0}}, x_a};
   assign den_in  = {1'b0, hp_a} + {1'b0, x_a};

   logic         d1_valid_ff [0:W];
   logic         d1_pass_ff  [0:W];
   logic [W-1:0] d1_r_ff     [0:W];
   logic [W-1:0] d1_g_ff     [0:W];
   logic [W-1:0] d1_b_ff     [0:W];
   logic [W-1:0] d1_m_ff     [0:W];
   logic [W:0]   d1_den_ff   [0:W];
   logic [W:0]   d1_rem_ff   [0:W];
   logic [W-1:0] d1_low_ff   [0:W];
   logic [W-1:0] d1_q_ff     [0:W];

   always_ff @(posedge clock) begin
      if (reset) begin
         d1_valid_ff[0] <= 1'b0;
      end else if (en) begin
         d1_valid_ff[0] <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d1_pass_ff[0] <= a_pass_ff;
         d1_r_ff[0]    <= a_r_ff;
         d1_g_ff[0]    <= a_g_ff;
         d1_b_ff[0]    <= a_b_ff;
         d1_m_ff[0]    <= a_m_ff;
         d1_den_ff[0]  <= den_in;
         d1_rem_ff[0]  <= {1'b0, prod_in[PW-1:W]};
         d1_low_ff[0]  <= prod_in[W-1:0];
         d1_q_ff[0]    <= '0;
      end
   end

   for (genvar k = 1; k <= W; k++) begin : g_div1
      logic [W+1:0] trial;
      logic         fits;
      logic [W+1:0] rem_in;
      assign trial  = {d1_rem_ff[k-1], d1_low_ff[k-1][W-1]};
      assign fits   = trial >= {1'b0, d1_den_ff[k-1]};
      assign rem_in = fits ? trial - {1'b0, d1_den_ff[k-1]} : trial;

      always_ff @(posedge clock) begin
         if (reset) begin
            d1_valid_ff[k] <= 1'b0;
         end else if (en) begin
            d1_valid_ff[k] <= d1_valid_ff[k-1];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            d1_pass_ff[k] <= d1_pass_ff[k-1];
            d1_r_ff[k]    <= d1_r_ff[k-1];
            d1_g_ff[k]    <= d1_g_ff[k-1];
            d1_b_ff[k]    <= d1_b_ff[k-1];
            d1_m_ff[k]    <= d1_m_ff[k-1];
            d1_den_ff[k]  <= d1_den_ff[k-1];
            d1_rem_ff[k]  <= rem_in[W:0];
            d1_low_ff[k]  <= d1_low_ff[k-1] << 1;
            d1_q_ff[k]    <= {d1_q_ff[k-1][W-2:0], fits};
         end
      end
   end

   // stage C (index 0 of the second divider): f and channel products
   logic [W-1:0] f_c;
   assign f_c = knee_ff + d1_q_ff[W];

   logic          d2_valid_ff [0:W];
   logic          d2_pass_ff  [0:W];
   logic [W-1:0]  d2_m_ff     [0:W];
   logic [W-1:0]  d2_orig_ff  [0:W][0:2];
   logic [W:0]    d2_rem_ff   [0:W][0:2];
   logic [W-1:0]  d2_low_ff   [0:W][0:2];
   logic [W-1:0]  d2_q_ff     [0:W][0:2];

   logic [W-1:0]  chan_c [0:2];
   assign chan_c[0] = d1_r_ff[W];
   assign chan_c[1] = d1_g_ff[W];
   assign chan_c[2] = d1_b_ff[W];

   always_ff @(posedge clock) begin
      if (reset) begin
         d2_valid_ff[0] <= 1'b0;
      end else if (en) begin
         d2_valid_ff[0] <= d1_valid_ff[W];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d2_pass_ff[0] <= d1_pass_ff[W];
         d2_m_ff[0]    <= d1_m_ff[W];
      end
   end

   for (genvar c = 0; c < 3; c++) begin : g_lane
      logic [PW-1:0] cprod_in;
      assign cprod_in = {{W{1'b0}}, chan_c[c]} * {{W{1'b0}}, f_c};

      always_ff @(posedge clock) begin
         if (en) begin
            d2_orig_ff[0][c] <= chan_c[c];
            d2_rem_ff[0][c]  <= {1'b0, cprod_in[PW-1:W]};
            d2_low_ff[0][c]  <= cprod_in[W-1:0];
            d2_q_ff[0][c]    <= '0;
         end
      end

      for (genvar k = 1; k <= W; k++) begin : g_div2
         logic [W+1:0] trial;
         logic         fits;
         logic [W+1:0] rem_in;
         assign trial  = {d2_rem_ff[k-1][c], d2_low_ff[k-1][c][W-1]};
         assign fits   = trial >= {2'b00, d2_m_ff[k-1]};
         assign rem_in = fits ? trial - {2'b00, d2_m_ff[k-1]} : trial;

         always_ff @(posedge clock) begin
            if (en) begin
               d2_orig_ff[k][c] <= d2_orig_ff[k-1][c];
               d2_rem_ff[k][c]  <= rem_in[W:0];
               d2_low_ff[k][c]  <= d2_low_ff[k-1][c] << 1;
               d2_q_ff[k][c]    <= {d2_q_ff[k-1][c][W-2:0], fits};
            end
         end
      end
   end

   for (genvar k = 1; k <= W; k++) begin : g_div2_ctl
      always_ff @(posedge clock) begin
         if (reset) begin
            d2_valid_ff[k] <= 1'b0;
         end else if (en) begin
            d2_valid_ff[k] <= d2_valid_ff[k-1];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            d2_pass_ff[k] <= d2_pass_ff[k-1];
            d2_m_ff[k]    <= d2_m_ff[k-1];
         end
      end
   end

   // output register
   logic         out_pass_ff;
   logic [W-1:0] out_r_ff, out_g_ff, out_b_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en) begin
         out_valid_ff <= d2_valid_ff[W];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_pass_ff <= d2_pass_ff[W];
         out_r_ff    <= d2_pass_ff[W] ? d2_orig_ff[W][0] : d2_q_ff[W][0];
         out_g_ff    <= d2_pass_ff[W] ? d2_orig_ff[W][1] : d2_q_ff[W][1];
         out_b_ff    <= d2_pass_ff[W] ? d2_orig_ff[W][2] : d2_q_ff[W][2];
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_red_out        = out_r_ff;
   assign rsp_green_out      = out_g_ff;
   assign rsp_blue_out       = out_b_ff;
   assign rsp_was_compressed = !out_pass_ff;

`ifndef ASSERT_OFF
   a_peak_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_was_compressed |->
         rsp_red_out <= peak_ff && rsp_green_out <= peak_ff && rsp_blue_out <= peak_ff)
      else $error("compressed channel above peak");

   a_no_headroom: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (knee_ff >= peak_ff || peak_ff <= FIXED_ONE) |-> !rsp_was_compressed)
      else $error("compression without headroom");

   a_above_knee: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_was_compressed |->
         rsp_red_out >= knee_ff || rsp_green_out >= knee_ff || rsp_blue_out >= knee_ff)
      else $error("compressed maximum below knee");
`endif

endmodule
